@@ rtl/line_edit_buffer_engine_assert.svh @@
// assertion helpers for the line edit buffer engine
`ifndef LINE_EDIT_BUFFER_ENGINE_ASSERT_SVH
`define LINE_EDIT_BUFFER_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LEBE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line edit buffer engine check failed");

// next-cycle implication, checked out of reset
`define LEBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line edit buffer engine check failed");

`endif

@@ rtl/lebe_pkg.sv @@
`timescale 1ns / 1ps
package lebe_pkg;

  localparam int DEF_MAX_CAPACITY = 256;
  localparam int BYTE_W           = 8;
  localparam int CAP_W            = 9;
  localparam int OP_W             = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_HOME      = 4'd0,
    OP_END       = 4'd1,
    OP_LEFT      = 4'd2,
    OP_RIGHT     = 4'd3,
    OP_BACKSPACE = 4'd4,
    OP_DELETE    = 4'd5,
    OP_INSERT    = 4'd6,
    OP_ARM       = 4'd7,
    OP_READ      = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DOWN,
    S_UP,
    S_DRAIN,
    S_CHAR,
    S_OUT
  } state_e;

endpackage

@@ rtl/lebe_store.sv @@
`timescale 1ns / 1ps
module lebe_store
  import lebe_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/line_edit_buffer_engine.sv @@
`timescale 1ns / 1ps
// Single-line edit buffer: one edit word in, one status word out. The text sits in a
// one-write, one-read synchronous byte memory; insert, delete and backspace move the
// bytes behind the cursor one place per cycle through that memory's single write port.
// Moves, arm replace, bad codes, failed edits and backspaces or deletes that move no
// byte go to S_OUT; a read passes S_READ first; backspace and delete shift bytes down
// through S_DOWN and S_DRAIN; insert shifts bytes up through S_UP and S_DRAIN if any
// byte moves, then writes the typed byte in S_CHAR; S_OUT waits for the output register.
// The next word is taken as soon as the result is in the output register. There is
// no clearing pass after reset; the capacity register may be written at any time the
// engine is idle.
`include "line_edit_buffer_engine_assert.svh"
module line_edit_buffer_engine
  import lebe_pkg::*;
#(
  parameter int MAX_CAPACITY = DEF_MAX_CAPACITY
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CAP_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // operation[3:0], char_in[11:4], read_index[19:12], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // changed[0], cursor_out[8:1], length_out[16:9], read_byte[24:17], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int AW = $clog2(MAX_CAPACITY);
  localparam int CW = $clog2(MAX_CAPACITY + 1);

  state_e state_q, state_d;

  logic [CAP_W-1:0]  cap_q;
  logic [AW-1:0]     len_q, len_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic              rep_q, rep_d;

  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     end_q, end_d;
  logic              ins_q, ins_d;
  logic [BYTE_W-1:0] ch_q, ch_d;
  logic              pw_valid_q, pw_valid_d;
  logic [AW-1:0]     pw_addr_q, pw_addr_d;

  logic              chg_q, chg_d;
  logic [AW-1:0]     rlen_q, rlen_d;
  logic              hit_q, hit_d;

  logic              m_valid_q, m_valid_d;
  logic              res_chg_q, res_chg_d;
  logic [BYTE_W-1:0] res_cur_q, res_cur_d;
  logic [BYTE_W-1:0] res_len_q, res_len_d;
  logic [BYTE_W-1:0] res_byte_q, res_byte_d;

  logic              accept;
  op_e               op;
  logic [BYTE_W-1:0] char_in;
  logic [BYTE_W-1:0] read_index;

  logic [CW-1:0]     cap_eff;
  logic              cap_zero;
  logic [CW-1:0]     cap_m1;
  logic [AW-1:0]     len_norm;
  logic [AW-1:0]     len_eff;
  logic [AW-1:0]     cur_eff;
  logic [AW-1:0]     ins_len;
  logic [AW-1:0]     ins_cur;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  assign op         = op_e'(s_axis_tdata_i[3:0]);
  assign char_in    = s_axis_tdata_i[11:4];
  assign read_index = s_axis_tdata_i[19:12];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // capacity clamp and normalization of the stored length and cursor
  always_comb begin
    if ({23'd0, cap_q} > 32'(MAX_CAPACITY)) begin
      cap_eff = CW'(MAX_CAPACITY);
    end else begin
      cap_eff = CW'(cap_q);
    end
    cap_zero = (cap_eff == '0);
    cap_m1   = cap_eff - CW'(1);
    if (!cap_zero && (CW'(len_q) > cap_m1)) begin
      len_norm = AW'(cap_m1);
    end else begin
      len_norm = len_q;
    end
    len_eff = cap_zero ? '0 : len_norm;
    cur_eff = (cur_q > len_eff) ? len_eff : cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    cur_d      = cur_q;
    rep_d      = rep_q;
    ptr_d      = ptr_q;
    end_d      = end_q;
    ins_d      = ins_q;
    ch_d       = ch_q;
    pw_valid_d = 1'b0;
    pw_addr_d  = pw_addr_q;
    chg_d      = chg_q;
    rlen_d     = rlen_q;
    hit_d      = hit_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    res_chg_d  = res_chg_q;
    res_cur_d  = res_cur_q;
    res_len_d  = res_len_q;
    res_byte_d = res_byte_q;
    ins_len    = len_eff;
    ins_cur    = cur_eff;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          len_d   = len_norm;
          cur_d   = cur_eff;
          chg_d   = 1'b0;
          rlen_d  = len_eff;
          hit_d   = 1'b0;
          ins_d   = 1'b0;
          ch_d    = char_in;
          state_d = S_OUT;
          case (op)
            OP_HOME: begin
              rep_d = 1'b0;
              if (cur_eff != '0) begin
                cur_d = '0;
                chg_d = 1'b1;
              end
            end
            OP_END: begin
              rep_d = 1'b0;
              if (cur_eff != len_eff) begin
                cur_d = len_eff;
                chg_d = 1'b1;
              end
            end
            OP_LEFT: begin
              rep_d = 1'b0;
              if (cur_eff != '0) begin
                cur_d = cur_eff - AW'(1);
                chg_d = 1'b1;
              end
            end
            OP_RIGHT: begin
              rep_d = 1'b0;
              if (cur_eff < len_eff) begin
                cur_d = cur_eff + AW'(1);
                chg_d = 1'b1;
              end
            end
            OP_BACKSPACE: begin
              rep_d = 1'b0;
              if (!cap_zero && cur_eff != '0) begin
                cur_d  = cur_eff - AW'(1);
                len_d  = len_eff - AW'(1);
                rlen_d = len_eff - AW'(1);
                chg_d  = 1'b1;
                if (cur_eff < len_eff) begin
                  ptr_d   = cur_eff;
                  end_d   = len_eff - AW'(1);
                  state_d = S_DOWN;
                end
              end
            end
            OP_DELETE: begin
              rep_d = 1'b0;
              if (!cap_zero && cur_eff < len_eff) begin
                len_d  = len_eff - AW'(1);
                rlen_d = len_eff - AW'(1);
                chg_d  = 1'b1;
                if (cur_eff + AW'(1) < len_eff) begin
                  ptr_d   = cur_eff + AW'(1);
                  end_d   = len_eff - AW'(1);
                  state_d = S_DOWN;
                end
              end
            end
            OP_INSERT: begin
              if (!cap_zero) begin
                if (rep_q) begin
                  ins_len = '0;
                  ins_cur = '0;
                  rep_d   = 1'b0;
                  len_d   = '0;
                  cur_d   = '0;
                  rlen_d  = '0;
                end
                if (CW'(ins_len) + CW'(1) < cap_eff) begin
                  cur_d  = ins_cur + AW'(1);
                  len_d  = ins_len + AW'(1);
                  rlen_d = ins_len + AW'(1);
                  chg_d  = 1'b1;
                  ins_d  = 1'b1;
                  end_d  = ins_cur;
                  if (ins_len > ins_cur) begin
                    ptr_d   = ins_len - AW'(1);
                    state_d = S_UP;
                  end else begin
                    state_d = S_CHAR;
                  end
                end
              end
            end
            OP_ARM: begin
              rep_d = 1'b1;
            end
            OP_READ: begin
              if (32'(read_index) < 32'(len_eff)) begin
                hit_d   = 1'b1;
                ptr_d   = AW'(read_index);
                state_d = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_OUT;
      end
      S_DOWN: begin
        pw_valid_d = 1'b1;
        pw_addr_d  = ptr_q - AW'(1);
        if (ptr_q == end_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_UP: begin
        pw_valid_d = 1'b1;
        pw_addr_d  = ptr_q + AW'(1);
        if (ptr_q == end_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q - AW'(1);
        end
      end
      S_DRAIN: begin
        state_d = ins_q ? S_CHAR : S_OUT;
      end
      S_CHAR: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          res_chg_d  = chg_q;
          res_cur_d  = BYTE_W'(cur_q);
          res_len_d  = BYTE_W'(rlen_q);
          res_byte_d = hit_q ? mem_rdata : '0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CAP_RESET;
      len_q      <= '0;
      cur_q      <= '0;
      rep_q      <= 1'b0;
      pw_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      len_q      <= len_d;
      cur_q      <= cur_d;
      rep_q      <= rep_d;
      pw_valid_q <= pw_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    end_q      <= end_d;
    ins_q      <= ins_d;
    ch_q       <= ch_d;
    pw_addr_q  <= pw_addr_d;
    chg_q      <= chg_d;
    rlen_q     <= rlen_d;
    hit_q      <= hit_d;
    res_chg_q  <= res_chg_d;
    res_cur_q  <= res_cur_d;
    res_len_q  <= res_len_d;
    res_byte_q <= res_byte_d;
  end

  // each shift write lands in the cycle after its read; the typed byte lands last
  assign mem_we    = pw_valid_q || (state_q == S_CHAR);
  assign mem_waddr = (state_q == S_CHAR) ? end_q : pw_addr_q;
  assign mem_wdata = (state_q == S_CHAR) ? ch_q : mem_rdata;

  lebe_store #(
    .DEPTH (MAX_CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (ptr_q),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, res_byte_q, res_len_q, res_cur_q, res_chg_q};

  `LEBE_ASSERT_NOW(a_cursor_in_text, 1'b1, cur_q <= len_q)
  `LEBE_ASSERT_NOW(a_no_write_when_idle, state_q == S_IDLE, !mem_we)
  `LEBE_ASSERT_NEXT(a_drain_writes, state_q == S_DRAIN, !pw_valid_q)
  `LEBE_ASSERT_NEXT(a_out_loads, (state_q == S_OUT) && !(m_valid_q && !m_axis_tready_i),
                    m_valid_q && (state_q == S_IDLE))

endmodule
